// ===== design/pcb_pkg.sv =====
// Shared types and constants for the pixel colorize blend core.
`timescale 1ns / 1ps
package pcb_pkg;

    // Blend mode codes, as written to the blend_mode register
    typedef enum logic [2:0] {
        MODE_PASS = 3'd0,
        MODE_AVG  = 3'd1,
        MODE_ADD  = 3'd2,
        MODE_SUB  = 3'd3,
        MODE_SUB2 = 3'd4,
        MODE_MUL  = 3'd5,
        MODE_DIV  = 3'd6,
        MODE_DIV2 = 3'd7
    } t_mode;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_TOL  = 2'd1;
    localparam logic [1:0] REG_TINT = 2'd2;

    localparam int ADDR_W = 4;
    localparam int TOL_W  = 9;
    localparam int TINT_W = 24;
    localparam logic [7:0] BYTE_MAX = 8'hFF;

endpackage

// ===== design/pixel_colorize_blend_core.sv =====
// Top level of the pixel colorize blend core.
//
// Blends each incoming pixel (blue, green, red, spare bytes) with a tint color
// set over the APB-style port (blend_mode at 0x0, tolerance at 0x4, tint at
// 0x8). The user must write registers only while the pipeline is empty; the
// block does not enforce this. Input transactions use i_valid/o_ready,
// output transactions o_valid/i_ready. There is one stage for the tolerance
// products, one for the combine (add, subtract, and the multiply product),
// then nine divider stages: an overflow check (which also saturates the
// multiply result) followed by eight restoring steps, one quotient bit each.
// Every mode goes through the same depth. Throughput is one pixel per clock
// while the receiver takes results. The whole pipeline advances together:
// when the last stage holds a result that the receiver does not take, every
// stage holds and o_ready drops, so nothing is lost or repeated.
// Reset clears all stage valid bits and the configuration registers to zero
// (passthrough mode); there is no clearing pass.
`timescale 1ns / 1ps
module pixel_colorize_blend_core #(
    parameter int TOL_FRAC_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_in_blue,
    input  logic [7:0]                 i_in_green,
    input  logic [7:0]                 i_in_red,
    input  logic [7:0]                 i_in_spare,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_out_blue,
    output logic [7:0]                 o_out_green,
    output logic [7:0]                 o_out_red,
    output logic [7:0]                 o_out_spare
);
    import pcb_pkg::*;

    localparam int LAT = 11;

    t_mode              mode;
    logic [TOL_FRAC_BITS:0] t;
    logic [TINT_W-1:0]  tint;
    logic               en;
    logic [LAT-1:0]     r_v;

    pcb_cfg #(.F(TOL_FRAC_BITS)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (mode),
        .o_t     (t),
        .o_tint  (tint)
    );

    // global advance: last stage empty or being taken
    assign en      = !r_v[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[LAT-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-2:0], i_valid};
        end
    end

    pcb_lane #(.F(TOL_FRAC_BITS)) u_blue (
        .i_clk (i_clk), .i_en (en), .i_mode (mode), .i_t (t),
        .i_a (tint[7:0]), .i_b (i_in_blue), .o_q (o_out_blue)
    );

    pcb_lane #(.F(TOL_FRAC_BITS)) u_green (
        .i_clk (i_clk), .i_en (en), .i_mode (mode), .i_t (t),
        .i_a (tint[15:8]), .i_b (i_in_green), .o_q (o_out_green)
    );

    pcb_lane #(.F(TOL_FRAC_BITS)) u_red (
        .i_clk (i_clk), .i_en (en), .i_mode (mode), .i_t (t),
        .i_a (tint[23:16]), .i_b (i_in_red), .o_q (o_out_red)
    );

    // spare channel blends against a zero tint byte
    pcb_lane #(.F(TOL_FRAC_BITS)) u_spare (
        .i_clk (i_clk), .i_en (en), .i_mode (mode), .i_t (t),
        .i_a (8'd0), .i_b (i_in_spare), .o_q (o_out_spare)
    );

endmodule

// ===== design/pcb_cfg.sv =====
// Configuration registers and tolerance conditioning.
`timescale 1ns / 1ps
module pcb_cfg #(
    parameter int F = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pcb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pcb_pkg::t_mode             o_mode,
    output logic [F:0]                 o_t,
    output logic [pcb_pkg::TINT_W-1:0] o_tint
);
    import pcb_pkg::*;

    localparam int EW = (F + 1 > TOL_W) ? F + 1 : TOL_W;
    localparam logic [F:0] ONE = (F + 1)'(1) << F;

    t_mode               r_mode;
    logic [TOL_W-1:0]    r_tol;
    logic [TINT_W-1:0]   r_tint;
    logic [EW-1:0]       tol_ext;
    logic [F:0]          tol_m;
    logic                wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
            r_tol  <= '0;
            r_tint <= '0;
        end else if (wr) begin
            unique case (paddr[3:2])
                REG_MODE: r_mode <= t_mode'(pwdata[2:0]);
                REG_TOL:  r_tol  <= pwdata[TOL_W-1:0];
                REG_TINT: r_tint <= pwdata[TINT_W-1:0];
                default:  ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            REG_MODE: prdata = {29'd0, r_mode};
            REG_TOL:  prdata = {23'd0, r_tol};
            REG_TINT: prdata = {8'd0, r_tint};
            default:  prdata = '0;
        endcase
    end

    // mask to F+1 bits, then clamp to 1.0
    assign tol_ext = EW'(r_tol);
    assign tol_m   = tol_ext[F:0];
    assign o_t     = (tol_m > ONE) ? ONE : tol_m;
    assign o_mode  = r_mode;
    assign o_tint  = r_tint;

endmodule

// ===== design/pcb_lane.sv =====
// One channel's blend datapath: products, combine, and a bit-per-stage divider.
`timescale 1ns / 1ps
module pcb_lane #(
    parameter int F = 8
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  pcb_pkg::t_mode i_mode,
    input  logic [F:0]     i_t,
    input  logic [7:0]     i_a,
    input  logic [7:0]     i_b,
    output logic [7:0]     o_q
);
    import pcb_pkg::*;

    localparam int MW = F + 2;
    localparam int PW = F + 10;
    localparam int DW = PW + 8;
    localparam int NS = 9;
    localparam int SH = 2 * F + 6;
    localparam logic [MW-1:0] TWO   = MW'(1) << (F + 1);
    localparam logic [MW-1:0] TENTH = MW'((2 ** (F + 1) + 5) / 10);

    // stage 1 signals
    logic [MW-1:0] taa, tbb, taar, m1, m2;
    logic [8:0]    sum;
    logic [7:0]    u;
    t_mode         r1_mode;
    logic [PW-1:0] r1_x, r1_y;
    logic [7:0]    r1_b;

    // stage 2 signals
    logic [PW:0]     sxy, sdf;
    logic [PW-1:0]   sav;
    logic [7:0]      n2_res;
    logic            n2_done;
    logic [7:0]      r2_res;
    logic            r2_mul, r2_done;
    logic [2*PW-1:0] r2_prod;
    logic [PW-1:0]   r2_num, r2_den;

    // divider stages
    logic [7:0]      r_q    [NS];
    logic [PW-1:0]   r_rem  [NS];
    logic [PW-1:0]   r_den  [NS];
    logic            r_done [NS];
    logic [2*PW-1:0] pq;
    logic [7:0]      q0;

    // tolerance terms and multiplier operands
    always_comb begin
        taa  = MW'(i_t);
        tbb  = TWO - taa;
        taar = (taa < TENTH) ? TENTH : taa;
        sum  = {1'b0, i_a} + {1'b0, i_b};
        u    = (i_mode == MODE_AVG) ? sum[8:1] : i_a;
        case (i_mode)
            MODE_AVG:  m1 = taa;
            MODE_MUL:  m1 = taar;
            MODE_DIV2: m1 = tbb;
            default:   m1 = taa;
        endcase
        m2 = (i_mode == MODE_DIV2) ? taar : tbb;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= i_mode;
            r1_x    <= PW'(m1) * PW'(u);
            r1_y    <= PW'(m2) * PW'(i_b);
            r1_b    <= i_b;
        end
    end

    // stage 2: pass, average, add and subtract modes finish here; multiply product and divide operands set up
    always_comb begin
        sxy     = {1'b0, r1_x} + {1'b0, r1_y};
        sdf     = '0;
        sav     = r1_x >> F;
        n2_res  = '0;
        n2_done = 1'b1;
        case (r1_mode)
            MODE_PASS: n2_res = r1_b;
            MODE_AVG:  n2_res = (sav > PW'(BYTE_MAX)) ? BYTE_MAX : sav[7:0];
            MODE_ADD: begin
                sdf    = sxy >> (F + 1);
                n2_res = (sdf > (PW + 1)'(BYTE_MAX)) ? BYTE_MAX : sdf[7:0];
            end
            MODE_SUB: begin
                sdf = ({1'b0, r1_x} - {1'b0, r1_y}) >> (F + 1);
                if (r1_x > r1_y)
                    n2_res = (sdf > (PW + 1)'(BYTE_MAX)) ? BYTE_MAX : sdf[7:0];
            end
            MODE_SUB2: begin
                sdf = ({1'b0, r1_y} - {1'b0, r1_x}) >> (F + 1);
                if (r1_y > r1_x)
                    n2_res = (sdf > (PW + 1)'(BYTE_MAX)) ? BYTE_MAX : sdf[7:0];
            end
            MODE_MUL: n2_res = '0;
            MODE_DIV, MODE_DIV2: n2_done = (r1_b == 8'd0) || (r1_y == '0);
            default: n2_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_res  <= n2_res;
            r2_done <= n2_done;
            r2_mul  <= (r1_mode == MODE_MUL);
            r2_prod <= (2 * PW)'(r1_x) * (2 * PW)'(r1_y);
            r2_num  <= r1_x;
            r2_den  <= r1_y;
        end
    end

    // multiply mode result enters the divider chain as a finished value
    assign pq = r2_prod >> SH;
    assign q0 = r2_mul ? ((pq > (2 * PW)'(BYTE_MAX)) ? BYTE_MAX : pq[7:0]) : r2_res;

    // divider stage 0: overflow check against den * 256
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= r2_den;
            r_rem[0] <= r2_num;
            if (r2_done) begin
                r_q[0]    <= q0;
                r_done[0] <= 1'b1;
            end else if (DW'(r2_num) >= (DW'(r2_den) << 8)) begin
                r_q[0]    <= BYTE_MAX;
                r_done[0] <= 1'b1;
            end else begin
                r_q[0]    <= '0;
                r_done[0] <= 1'b0;
            end
        end
    end

    // restoring steps, one quotient bit per stage, MSB first
    for (genvar j = 1; j < NS; j++) begin : g_step
        localparam int K = NS - 1 - j;
        logic [DW-1:0] dsh;
        logic          ge;
        assign dsh = DW'(r_den[j-1]) << K;
        assign ge  = DW'(r_rem[j-1]) >= dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[j]  <= r_den[j-1];
                r_done[j] <= r_done[j-1];
                if (!r_done[j-1] && ge) begin
                    r_rem[j]  <= r_rem[j-1] - dsh[PW-1:0];
                    r_q[j]    <= r_q[j-1] | (8'd1 << K);
                end else begin
                    r_rem[j]  <= r_rem[j-1];
                    r_q[j]    <= r_q[j-1];
                end
            end
        end
    end

    assign o_q = r_q[NS-1];

endmodule
